FILE: rtl/scratchpad_crc_temp_check_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros for the scratchpad CRC check block
// Clocked on clk. Checks are either held off during reset or run through it.
// -----------------------------------------------------------------------------
`ifndef SCRATCHPAD_CRC_TEMP_CHECK_MACROS_SVH
`define SCRATCHPAD_CRC_TEMP_CHECK_MACROS_SVH

// check that is held off while reset is asserted
`define SCTC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check that also runs during reset
`define SCTC_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/sctc_pkg.sv
// -----------------------------------------------------------------------------
// sctc_pkg
// Types, constants and the CRC-8 byte update for the scratchpad CRC check.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sctc_pkg;

	localparam logic [7:0] CRC_POLY  = 8'h8C;
	localparam logic [7:0] CRC_INIT  = 8'h00;
	localparam logic [3:0] CRC_BYTES = 4'd8;
	localparam logic [3:0] IDX_TEMP_LO = 4'd0;
	localparam logic [3:0] IDX_TEMP_HI = 4'd1;

	typedef enum logic [1:0] {
		STATUS_OK   = 2'd0,
		STATUS_CRC  = 2'd1,
		STATUS_FAIL = 2'd2
	} status_t;

	// reflected CRC-8, one byte, LSB first
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
		logic [7:0] crc;
		logic [7:0] d;
		crc = crc_in;
		d   = data;
		for (int k = 0; k < 8; k++) begin
			if (crc[0] ^ d[0]) begin
				crc = (crc >> 1) ^ CRC_POLY;
			end else begin
				crc = crc >> 1;
			end
			d = d >> 1;
		end
		return crc;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/scratchpad_crc_temp_check.sv
// -----------------------------------------------------------------------------
// scratchpad_crc_temp_check
// Checks the CRC-8 of a nine-byte sensor scratchpad and extracts the
// temperature in whole degrees.
// -----------------------------------------------------------------------------
// Takes one item per clock cycle while the input is not stalled. An item is
// registered on entry, then the CRC update and frame bookkeeping run from the
// input register into the result register, which presents the result of the
// item that causes it (byte 8 or a failed byte). The input stalls only when a
// result is pending and the result register is still held by out_stall.
`timescale 1ns / 1ps
`default_nettype none

module scratchpad_crc_temp_check (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [7:0]        rx_byte,
	input  wire logic              byte_failed,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic signed [7:0]      temperature_c,
	output sctc_pkg::status_t      status
);
	import sctc_pkg::*;

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              failed_s1;

	logic [3:0]        byte_idx_q;
	logic [7:0]        crc_q;
	logic [7:0]        temp_lo_q;
	logic [7:0]        temp_hi_q;

	logic              out_valid_q;
	logic signed [7:0] temp_out_q;
	status_t           status_q;

	logic              is_check;
	logic              has_result;
	logic              advance;
	logic [7:0]        crc_next;

	assign is_check   = (byte_idx_q >= CRC_BYTES);
	assign has_result = failed_s1 || is_check;
	assign advance    = valid_s1 && (!has_result || !out_valid_q || !out_stall);
	assign in_stall   = valid_s1 && !advance;
	assign crc_next   = crc8_byte(crc_q, byte_s1);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1   <= rx_byte;
			failed_s1 <= byte_failed;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q <= '0;
			crc_q      <= CRC_INIT;
			temp_lo_q  <= '0;
			temp_hi_q  <= '0;
		end else if (advance) begin
			if (has_result) begin
				byte_idx_q <= '0;
				crc_q      <= CRC_INIT;
				temp_lo_q  <= '0;
				temp_hi_q  <= '0;
			end else begin
				crc_q      <= crc_next;
				byte_idx_q <= byte_idx_q + 4'd1;
				if (byte_idx_q == IDX_TEMP_LO) begin
					temp_lo_q <= byte_s1;
				end
				if (byte_idx_q == IDX_TEMP_HI) begin
					temp_hi_q <= byte_s1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			if (failed_s1) begin
				temp_out_q <= '0;
				status_q   <= STATUS_FAIL;
			end else if (crc_q == byte_s1) begin
				temp_out_q <= signed'({temp_hi_q[3:0], temp_lo_q[7:4]});
				status_q   <= STATUS_OK;
			end else begin
				temp_out_q <= '0;
				status_q   <= STATUS_CRC;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign temperature_c = temp_out_q;
	assign status        = status_q;

endmodule

`default_nettype wire

FILE: rtl/sctc_checker.sv
// -----------------------------------------------------------------------------
// sctc_checker
// Port-level checks for scratchpad_crc_temp_check, bound to the top level.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "scratchpad_crc_temp_check_macros.svh"

module sctc_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire logic [7:0]        rx_byte,
	input wire logic              byte_failed,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic signed [7:0] temperature_c,
	input wire sctc_pkg::status_t status
);
	import sctc_pkg::*;

	logic in_take;
	logic in_held;
	logic out_held;
	assign in_take  = in_valid && !in_stall;
	assign in_held  = in_valid && in_stall;
	assign out_held = out_valid && out_stall;

	// held result keeps its value
	`SCTC_ASSERT(a_out_hold,
		out_held |=> out_valid && $stable(temperature_c) && $stable(status),
		"stalled result changed")
	// stalled input item keeps its value
	`SCTC_ASSERT(a_in_hold,
		in_held |=> in_valid && $stable(rx_byte) && $stable(byte_failed),
		"stalled input item changed")
	// temperature is zero unless the frame passed
	`SCTC_ASSERT(a_temp_zero,
		out_valid && status != STATUS_OK |-> temperature_c == 8'sd0,
		"temperature not zero on error status")
	// input only backs up behind a blocked result
	`SCTC_ASSERT(a_stall_cause, in_stall |-> out_held, "input stalled without blocked result")
	// reset leaves nothing pending
	`SCTC_ASSERT_RST(a_reset_idle,
		!arst_n |-> !out_valid && !in_stall && !in_take,
		"activity during reset")

endmodule

bind scratchpad_crc_temp_check sctc_checker u_sctc_checker (.*);

`default_nettype wire
